>>> design/assert_macros.svh
// assertion macros for the scheduler rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every edge outside reset
`define CPTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked in the cycle after its antecedent
`define CPTS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

>>> design/cpts_pkg.sv
// package for the counter priority task scheduler
// types, command codes and sizes shared by all modules; no dependencies
package cpts_pkg;
	localparam int MaxTasks = 16;
	localparam int SlotW = $clog2(MaxTasks);
	localparam int TotW = $clog2(MaxTasks + 1);
	localparam int QDepth = 2;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_TICK = 3'd1;
	localparam logic [2:0] CMD_YIELD = 3'd2;
	localparam logic [2:0] CMD_EXIT = 3'd3;
	localparam logic [2:0] CMD_SET = 3'd4;
	localparam logic [2:0] CMD_PEN = 3'd5;
	localparam logic [2:0] CMD_PDIS = 3'd6;

	localparam logic [1:0] ST_RUNNING = 2'd0;
	localparam logic [1:0] ST_ZOMBIE = 2'd2;

	localparam logic [0:0] CFG_PRIO = 1'b0;
	localparam logic [0:0] CFG_CNT = 1'b1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] task_index;
		logic [1:0] task_state;
		logic [6:0] new_priority;
		logic [6:0] start_counter;
		logic [7:0] start_preempt;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  current_slot_out;
		logic        switched;
		logic        idle;
		logic [15:0] assigned_id;
		logic        status;
	} out_item_t;

	// classified command between front and back
	typedef struct packed {
		in_item_t item;
		logic     sched;
	} work_t;
endpackage

>>> design/counter_priority_task_scheduler.sv
// channel | dir | handshake        | payload
// in      | in  | in_valid/in_stall   | cpts_pkg::in_item_t
// out     | out | out_valid/out_stall | cpts_pkg::out_item_t
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// non-scheduling commands finish in the back end's idle state; a scheduling pass
// walks the table in one scan, plus a refresh walk and a second scan when needed.
// a two-entry queue lets beats be taken while the back end works.
// reset is asynchronous; slot zero holds the initial task.
// the back end waits while a finished result is still stalled.
module counter_priority_task_scheduler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cpts_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cpts_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import cpts_pkg::*;
	`include "assert_macros.svh"

	logic w_valid, w_take;
	work_t w_data;

	assign cfg_ready = 1'b1;

	// front end and queue
	cpts_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .w_valid, .w_take, .w_data
	);

	// back end
	cpts_back u_back (
		.clk, .arst_n, .w_valid, .w_take, .w_data,
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.out_valid, .out_stall, .out_data
	);

	`CPTS_ASSERT(a_take_valid, !w_take || w_valid, "take from empty queue")
	`CPTS_ASSERT(a_sw_slot, !out_valid || !(out_data.switched && out_data.idle),
		"switched while idle")
	`CPTS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "result dropped")
endmodule

>>> design/cpts_front.sv
// front end: accepts command beats, classifies them, queues them for the back end
// depends on cpts_pkg
module cpts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpts_pkg::in_item_t in_data,
	output logic              w_valid,
	input  logic              w_take,
	output cpts_pkg::work_t   w_data
);
	import cpts_pkg::*;

	localparam int PW = $clog2(QDepth);

	work_t q_q [QDepth];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push;
	work_t cls;

	// classify: which commands may need a scheduling pass
	always_comb begin
		cls.item = in_data;
		cls.sched = (in_data.cmd == CMD_TICK) || (in_data.cmd == CMD_YIELD) ||
			(in_data.cmd == CMD_EXIT);
	end

	assign in_stall = (cnt_q == (PW+1)'(QDepth));
	assign push = in_valid && !in_stall;
	assign w_valid = (cnt_q != '0);
	assign w_data = q_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (w_take) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(w_take);
		end
	end
endmodule

>>> design/cpts_back.sv
// back end: task table, command execution and the scan/refresh sequencer
// depends on cpts_pkg
module cpts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               w_valid,
	output logic               w_take,
	input  cpts_pkg::work_t    w_data,
	input  logic               cfg_valid,
	input  logic [0:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cpts_pkg::out_item_t out_data
);
	import cpts_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_REFR, S_SCAN2, S_DONE} st_t;

	st_t st_q;
	logic [6:0] prio_q [MaxTasks];
	logic signed [15:0] slice_q [MaxTasks];
	logic [1:0] state_q [MaxTasks];
	logic [7:0] pre_q [MaxTasks];
	logic [TotW-1:0] total_q;
	logic [SlotW-1:0] run_q, idx_q, best_slot_q, before_q;
	logic [15:0] id_q;
	logic signed [16:0] best_q;
	logic idle_r_q;
	out_item_t res_q;
	logic ov_q;

	in_item_t it;
	logic [SlotW-1:0] cur;
	logic signed [15:0] dec;
	logic at_end;
	logic signed [16:0] refv;
	logic cand;

	assign it = w_data.item;
	assign cur = run_q;
	assign dec = (slice_q[cur] == 16'sh8000) ? slice_q[cur] : slice_q[cur] - 16'sd1;
	assign at_end = ({1'b0, idx_q} == total_q - 1'b1);
	assign refv = 17'(slice_q[idx_q] >>> 1) + 17'($signed({10'd0, prio_q[idx_q]}));
	assign cand = (state_q[idx_q] == ST_RUNNING) && (17'(slice_q[idx_q]) > best_q);
	assign w_take = (st_q == S_IDLE) && w_valid && !(ov_q && out_stall);
	assign out_valid = ov_q;
	assign out_data = res_q;

	// output register: a new result wins over the beat leaving in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if ((st_q == S_DONE) || (w_take && !w_data.sched) ||
			(w_take && it.cmd == CMD_TICK && (dec > 0 || pre_q[cur] != 8'd0))) ov_q <= 1'b1;
		else if (out_valid && !out_stall) ov_q <= 1'b0;
	end

	// sequencer and table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			total_q <= TotW'(1);
			run_q <= '0;
			id_q <= 16'd2;
			prio_q[0] <= 7'd1;
			slice_q[0] <= '0;
			state_q[0] <= ST_RUNNING;
			pre_q[0] <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_PRIO) prio_q[0] <= cfg_data;
				else slice_q[0] <= 16'($unsigned(cfg_data));
			end
			unique case (st_q)
				S_IDLE: if (w_take) begin
					res_q <= '0;
					res_q.current_slot_out <= 4'(run_q);
					before_q <= run_q;
					idx_q <= '0;
					best_q <= -17'sd1;
					best_slot_q <= run_q;
					unique case (it.cmd)
						CMD_ADD: begin
							if (total_q == TotW'(MaxTasks)) res_q.status <= 1'b1;
							else begin
								prio_q[total_q[SlotW-1:0]] <= it.new_priority;
								slice_q[total_q[SlotW-1:0]] <= 16'($unsigned(it.start_counter));
								state_q[total_q[SlotW-1:0]] <= it.task_state;
								pre_q[total_q[SlotW-1:0]] <= it.start_preempt;
								res_q.assigned_id <= id_q;
								id_q <= id_q + 16'd1;
								total_q <= total_q + 1'b1;
							end
						end
						CMD_TICK: begin
							if (dec > 0 || pre_q[cur] != 8'd0) slice_q[cur] <= dec;
							else begin
								slice_q[cur] <= '0;
								st_q <= S_SCAN1;
							end
						end
						CMD_YIELD: begin
							slice_q[cur] <= '0;
							st_q <= S_SCAN1;
						end
						CMD_EXIT: begin
							slice_q[cur] <= '0;
							state_q[cur] <= ST_ZOMBIE;
							st_q <= S_SCAN1;
						end
						CMD_SET:
							if ({1'b0, it.task_index[SlotW-1:0]} < total_q)
								state_q[it.task_index[SlotW-1:0]] <= it.task_state;
						CMD_PEN: if (pre_q[cur] != 8'd0) pre_q[cur] <= pre_q[cur] - 8'd1;
						CMD_PDIS: if (pre_q[cur] != 8'hff) pre_q[cur] <= pre_q[cur] + 8'd1;
						default: ;
					endcase
				end
				// first and second scan: best running counter
				S_SCAN1, S_SCAN2: begin
					if (cand) begin
						best_q <= 17'(slice_q[idx_q]);
						best_slot_q <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
					if (at_end) begin
						idx_q <= '0;
						if (st_q == S_SCAN1 && (cand ? slice_q[idx_q] == 16'sd0 : best_q == 17'sd0)) begin
							st_q <= S_REFR;
							best_q <= -17'sd1;
							best_slot_q <= run_q;
						end else st_q <= S_DONE;
					end
				end
				// refresh: half plus priority, saturating
				S_REFR: begin
					slice_q[idx_q] <= (refv > 17'sd32767) ? 16'sh7fff : 16'(refv);
					idx_q <= idx_q + 1'b1;
					if (at_end) begin
						idx_q <= '0;
						st_q <= S_SCAN2;
					end
				end
				S_DONE: begin
					st_q <= S_IDLE;
					if (best_q < 0) res_q.idle <= 1'b1;
					else begin
						run_q <= best_slot_q;
						res_q.current_slot_out <= 4'(best_slot_q);
						res_q.switched <= (best_slot_q != before_q);
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> bench/tb_counter_priority_task_scheduler.sv
// testbench for the counter priority task scheduler
// depends on design/cpts_pkg.sv and design/counter_priority_task_scheduler.sv
// directed table then random commands, each result checked against a scheduler predictor or a fixed expected value
`timescale 1ns / 1ps

module tb_counter_priority_task_scheduler;
	import cpts_pkg::*;

	localparam logic [2:0] CMD_NONE = 3'd7;
	localparam logic [1:0] ST_WAITING = 2'd1;
	localparam logic [1:0] ST_ODD = 2'd3;
	localparam int SliceMax = 32767;
	localparam int SliceMin = -32768;
	localparam int CycleLimit = 1000000;
	localparam int RandomItems = 1630;

	typedef struct {
		in_item_t  cmd_beat;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [6:0] cfg_data;

	counter_priority_task_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// scheduler shadow state
	int unsigned sh_prio [MaxTasks];
	int          sh_slice [MaxTasks];
	logic [1:0]  sh_state [MaxTasks];
	int unsigned sh_preempt [MaxTasks];
	int unsigned sh_total;
	int unsigned sh_running;
	logic [15:0] sh_next_id;

	out_item_t pending_results[$];
	dir_row_t  dir_rows[$];
	int mismatches = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// largest counter among running tasks, -1 when none qualifies
	function automatic int best_slice(inout int unsigned slot);
		int best;
		best = -1;
		for (int i = 0; i < sh_total; i++) begin
			if (sh_state[i] == ST_RUNNING && sh_slice[i] > best) begin
				best = sh_slice[i];
				slot = i;
			end
		end
		return best;
	endfunction

	// one scheduling pass with at most one refresh; returns idle
	function automatic bit reschedule();
		int unsigned slot;
		int best;
		int v;
		slot = sh_running;
		best = best_slice(slot);
		if (best == 0) begin
			for (int i = 0; i < sh_total; i++) begin
				v = ((sh_slice[i] >= 0) ? sh_slice[i] / 2 : -((-sh_slice[i] + 1) / 2))
					+ int'(sh_prio[i]);
				sh_slice[i] = (v > SliceMax) ? SliceMax : v;
			end
			best = best_slice(slot);
		end
		if (best < 0)
			return 1;
		sh_running = slot;
		return 0;
	endfunction

	// next result of the scheduler for one command beat
	function automatic out_item_t schedule_outcome(in_item_t c);
		out_item_t r;
		int unsigned was;
		int unsigned cur;
		was = sh_running;
		cur = sh_running;
		r = '0;
		case (c.cmd)
			CMD_ADD: begin
				if (sh_total >= MaxTasks) begin
					r.status = 1;
				end else begin
					sh_prio[sh_total] = c.new_priority;
					sh_slice[sh_total] = c.start_counter;
					sh_state[sh_total] = c.task_state;
					sh_preempt[sh_total] = c.start_preempt;
					r.assigned_id = sh_next_id;
					sh_next_id++;
					sh_total++;
				end
			end
			CMD_TICK: begin
				if (sh_slice[cur] > SliceMin)
					sh_slice[cur]--;
				if (!(sh_slice[cur] > 0 || sh_preempt[cur] > 0)) begin
					sh_slice[cur] = 0;
					r.idle = reschedule();
				end
			end
			CMD_YIELD: begin
				sh_slice[cur] = 0;
				r.idle = reschedule();
			end
			CMD_EXIT: begin
				sh_state[cur] = ST_ZOMBIE;
				sh_slice[cur] = 0;
				r.idle = reschedule();
			end
			CMD_SET: begin
				if (c.task_index < sh_total)
					sh_state[c.task_index] = c.task_state;
			end
			CMD_PEN: begin
				if (sh_preempt[cur] > 0)
					sh_preempt[cur]--;
			end
			CMD_PDIS: begin
				if (sh_preempt[cur] < 255)
					sh_preempt[cur]++;
			end
			default: ;
		endcase
		r.current_slot_out = sh_running[3:0];
		r.switched = (sh_running != was);
		return r;
	endfunction

	task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_PRIO)
			sh_prio[0] = val;
		else
			sh_slice[0] = val;
	endtask

	// offer one beat and wait for it to be taken, then maybe idle
	task automatic send_beat(input in_item_t c, input bit typed, input out_item_t want);
		out_item_t got;
		in_valid <= 1;
		in_data <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = schedule_outcome(c);
		pending_results.push_back(typed ? want : got);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every expected result has come
	task automatic drain(input int settle);
		in_valid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic in_item_t random_cmd();
		in_item_t c;
		int pick;
		c.task_index = $urandom_range(15);
		c.task_state = $urandom_range(3);
		c.new_priority = $urandom_range(127, 1);
		c.start_counter = $urandom_range(127);
		c.start_preempt = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 36) c.cmd = CMD_TICK;
		else if (pick < 48) c.cmd = CMD_YIELD;
		else if (pick < 53) c.cmd = CMD_EXIT;
		else if (pick < 73) c.cmd = CMD_SET;
		else if (pick < 80) c.cmd = CMD_ADD;
		else if (pick < 88) c.cmd = CMD_PEN;
		else if (pick < 96) c.cmd = CMD_PDIS;
		else c.cmd = CMD_NONE;
		// waking tasks up keeps the scheduler busy
		if (c.cmd == CMD_SET && $urandom_range(1)) c.task_state = ST_RUNNING;
		return c;
	endfunction

	task automatic add_row(input logic [2:0] op, input logic [3:0] idx, input logic [1:0] st,
		input logic [6:0] pri, input logic [6:0] cnt, input logic [7:0] pre,
		input bit typed, input out_item_t want);
		dir_row_t row;
		row.cmd_beat = '{op, idx, st, pri, cnt, pre};
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// receiver stall, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", out_data);
			end else begin
				exp_r = pending_results.pop_front();
				if (out_data !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: slot %0d/%0d sw %0d/%0d idle %0d/%0d id %0d/%0d st %0d/%0d",
							exp_r.current_slot_out, out_data.current_slot_out,
							exp_r.switched, out_data.switched, exp_r.idle, out_data.idle,
							exp_r.assigned_id, out_data.assigned_id,
							exp_r.status, out_data.status);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_counter_priority_task_scheduler: errors");
			$finish;
		end
	end

	initial begin
		out_item_t none;
		none = '0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = CFG_PRIO;
		cfg_data = '0;
		for (int i = 0; i < MaxTasks; i++) begin
			sh_prio[i] = 0;
			sh_slice[i] = 0;
			sh_state[i] = ST_RUNNING;
			sh_preempt[i] = 0;
		end
		sh_prio[0] = 1;
		sh_total = 1;
		sh_running = 0;
		sh_next_id = 2;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values of both registers, written back as they are
		write_reg(CFG_PRIO, 7'd1);
		write_reg(CFG_CNT, 7'd0);

		// tick on the lone initial task: refresh to one, same slot
		add_row(CMD_TICK, 0, ST_RUNNING, 1, 0, 0, 1, '{4'd0, 1'b0, 1'b0, 16'd0, 1'b0});
		add_row(CMD_ADD, 0, ST_RUNNING, 127, 127, 255, 1, '{4'd0, 1'b0, 1'b0, 16'd2, 1'b0});
		add_row(CMD_ADD, 0, ST_ODD, 1, 0, 0, 1, '{4'd0, 1'b0, 1'b0, 16'd3, 1'b0});
		add_row(CMD_YIELD, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_PDIS, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_TICK, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_PEN, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_PEN, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_SET, 15, ST_WAITING, 1, 0, 0, 0, none);
		add_row(CMD_NONE, 7, 3, 127, 127, 255, 0, none);
		add_row(CMD_SET, 2, ST_RUNNING, 1, 0, 0, 0, none);
		add_row(CMD_EXIT, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_SET, 0, ST_WAITING, 1, 0, 0, 0, none);
		add_row(CMD_SET, 1, ST_WAITING, 1, 0, 0, 0, none);
		add_row(CMD_SET, 2, ST_ZOMBIE, 1, 0, 0, 0, none);
		// nothing runnable: idle, slot kept
		add_row(CMD_YIELD, 0, 0, 1, 0, 0, 0, none);
		add_row(CMD_SET, 1, ST_RUNNING, 1, 0, 0, 0, none);
		add_row(CMD_TICK, 0, 0, 1, 0, 0, 0, none);
		for (int i = 0; i < 13; i++)
			add_row(CMD_ADD, 4'(i), 2'(i % 4), 7'(i * 9 + 1), 7'(i * 9), 8'(i * 19), 0, none);
		// table full
		add_row(CMD_ADD, 0, ST_RUNNING, 5, 5, 5, 1, '{4'd0, 1'b0, 1'b0, 16'd0, 1'b1});
		foreach (dir_rows[i]) begin
			// the table-full row keeps whatever slot the predictor holds
			if (dir_rows[i].typed && dir_rows[i].want.status)
				dir_rows[i].want.current_slot_out = 4'(sh_running);
			send_beat(dir_rows[i].cmd_beat, dir_rows[i].typed, dir_rows[i].want);
		end
		drain(60);

		// random phases with different idling and register settings
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 19; rx_idle_pct = 45;
					write_reg(CFG_PRIO, 7'd127);
					write_reg(CFG_CNT, 7'd127);
				end
				1: begin
					tx_idle_pct = 45; rx_idle_pct = 19;
					write_reg(CFG_PRIO, 7'($urandom_range(126, 2)));
					write_reg(CFG_CNT, 7'($urandom_range(126, 1)));
				end
				default: begin
					tx_idle_pct = 0; rx_idle_pct = 0;
					write_reg(CFG_PRIO, 7'd1);
					write_reg(CFG_CNT, 7'd0);
				end
			endcase
			for (int n = 0; n < RandomItems / 3; n++) begin
				if (n == 100 && ph != 1)
					hold_req = 1;
				if (n == 300)
					drain(0);
				send_beat(random_cmd(), 0, none);
			end
			drain(60);
		end

		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_counter_priority_task_scheduler: clean");
		else
			$display("tb_counter_priority_task_scheduler: errors");
		$finish;
	end
endmodule

>>> files.f
+incdir+design
design/cpts_pkg.sv
design/cpts_front.sv
design/cpts_back.sv
design/counter_priority_task_scheduler.sv
bench/tb_counter_priority_task_scheduler.sv
